// ===== sv/pcmfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfd_pkg
// Shared types and constants for the PCM formatter with noise-shaped dither.
// ----------------------------------------------------------------------------
package pcmfd_pkg;

  // Generator: next = state * 16807 mod (2^31 - 1)
  localparam int SEED_W     = 31;
  localparam int LCG_MULT_W = 15;
  localparam int PROD_W     = SEED_W + LCG_MULT_W;
  localparam logic [LCG_MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [SEED_W-1:0]     LCG_MOD  = 31'h7fff_ffff;
  localparam logic [SEED_W-1:0]     SEED_RESET = 31'd1;
  // Generator value one step past the reset seed
  localparam logic [SEED_W-1:0] RND_AHEAD_RESET =
    SEED_W'((64'(SEED_RESET) * 64'(LCG_MULT)) % 64'(LCG_MOD));

  // Dither datapath
  localparam int SAMPLE_W  = 32;
  localparam int ERR_W     = 32;
  localparam int ACC_W     = 36;
  localparam int OUT_SHIFT = 8;
  localparam int HALF_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int BYTE_BIAS = 128;
  localparam int LOW_MASK  = 8'hff;
  localparam logic signed [ACC_W-1:0] CLIP_MAX = 36'sd8388607;
  localparam logic signed [ACC_W-1:0] CLIP_MIN = -36'sd8388608;

  // Sample size codes (bytes_per_sample)
  localparam int BPS_W = 3;
  localparam logic [BPS_W-1:0] BPS_8     = 3'd1;
  localparam logic [BPS_W-1:0] BPS_16    = 3'd2;
  localparam logic [BPS_W-1:0] BPS_24    = 3'd3;
  localparam logic [BPS_W-1:0] BPS_32    = 3'd4;
  localparam logic [BPS_W-1:0] BPS_RESET = BPS_24;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPS    = 2'd0,
    CFG_STEREO = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      out_word;
    logic [BPS_W-1:0] out_bytes;
  } out_item_t;

  // Error-feedback taps of one channel
  typedef struct packed {
    logic signed [ERR_W-1:0] recent;
    logic signed [ERR_W-1:0] halved;
    logic signed [ERR_W-1:0] oldest;
  } taps_t;

endpackage

// ===== sv/pcmfd_lcg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfd_lcg
// One Park-Miller step: full 31x15 product folded modulo 2^31 - 1.
// ----------------------------------------------------------------------------
module pcmfd_lcg
  import pcmfd_pkg::*;
(
  input  logic [SEED_W-1:0] state_in,
  output logic [SEED_W-1:0] state_out
);

  logic [PROD_W-1:0] prod;
  logic [SEED_W:0]   fold;
  logic [SEED_W:0]   fold_sub;

  // 2^31 = 1 mod M, so high part folds onto low part; one correction
  always_comb begin
    prod      = PROD_W'(state_in) * PROD_W'(LCG_MULT);
    fold      = {1'b0, prod[SEED_W-1:0]} + (SEED_W+1)'(prod[PROD_W-1:SEED_W]);
    fold_sub  = fold - {1'b0, LCG_MOD};
    state_out = (fold >= {1'b0, LCG_MOD}) ? fold_sub[SEED_W-1:0] : fold[SEED_W-1:0];
  end

endmodule

// ===== sv/pcmfd_dither.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfd_dither
// 24-to-16-bit requantizer: error-feedback shaping, dither, clip, shift.
// ----------------------------------------------------------------------------
module pcmfd_dither
  import pcmfd_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] sample,
  input  taps_t                      taps,
  input  logic [BYTE_W-1:0]          rnd_old_lo,
  input  logic [BYTE_W-1:0]          rnd_new_lo,
  output taps_t                      taps_nxt,
  output logic [HALF_W-1:0]          word16
);

  logic signed [ACC_W-1:0] shaped;
  logic signed [ACC_W-1:0] dith;
  logic signed [ACC_W-1:0] shaped_c;
  logic signed [ACC_W-1:0] dith_c;
  logic signed [ACC_W-1:0] quant;
  logic signed [ACC_W-1:0] err;
  logic signed [ERR_W-1:0] half_adj;

  // Shaped sum and dithered value, wide enough that nothing wraps
  always_comb begin
    shaped = ACC_W'(sample) + ACC_W'($signed(taps.recent))
           - ACC_W'($signed(taps.halved)) + ACC_W'($signed(taps.oldest));
    dith   = shaped + ACC_W'(BYTE_BIAS) + ACC_W'(rnd_new_lo) - ACC_W'(rnd_old_lo);
  end

  // Clip to 24 bits; the shaped sum is clipped alongside on overflow
  always_comb begin
    dith_c   = dith;
    shaped_c = shaped;
    if (dith > CLIP_MAX) begin
      dith_c = CLIP_MAX;
      if (shaped > CLIP_MAX) shaped_c = CLIP_MAX;
    end else if (dith < CLIP_MIN) begin
      dith_c = CLIP_MIN;
      if (shaped < CLIP_MIN) shaped_c = CLIP_MIN;
    end
  end

  // Drop the low byte, form the new error and shift the taps
  always_comb begin
    quant           = dith_c & ~ACC_W'(LOW_MASK);
    err             = shaped_c - quant;
    half_adj        = $signed(taps.recent) + ERR_W'(taps.recent[ERR_W-1]);
    taps_nxt.recent = err[ERR_W-1:0];
    taps_nxt.halved = half_adj >>> 1;   // rounds toward zero
    taps_nxt.oldest = taps.halved;
    word16          = quant[OUT_SHIFT+HALF_W-1:OUT_SHIFT];
  end

endmodule

// ===== sv/pcm_format_with_noise_shaped_dither.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_format_with_noise_shaped_dither
// Formats one signed PCM sample per item into a little-endian output word.
//
// Input channel: in_valid / in_stall carry in_item (sample, channel).
// Output channel: out_valid / out_stall carry out_item (out_word, out_bytes).
// Config channel: cfg_valid / cfg_ready with cfg_index, cfg_data; always ready.
//   Index 0 bytes_per_sample, 1 stereo, 2 dither_seed (also reloads both
//   generator states). Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The per-channel feedback taps and the
//   precomputed next generator value are read and updated in the same cycle,
//   so back-to-back items on one channel need no spacing.
// Path: an accepted item is held in the input register; its result is then
//   loaded into the output register once that register is empty or not stalled.
// Stall: while out_stall holds a result, one more item is taken into the
//   input register; in_stall rises only when both registers are full.
// Reset (rst_n low, synchronous): pipeline empties, taps clear, generators
//   load seed 1, bytes_per_sample = 3, stereo = 1.
// ----------------------------------------------------------------------------
module pcm_format_with_noise_shaped_dither
  import pcmfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  // Config registers
  logic [BPS_W-1:0] bps_r, bps_nxt;
  logic             stereo_r, stereo_nxt;

  // Pipeline registers
  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_item_r;
  logic      out_v_r, out_v_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Per-channel state: taps, low byte of generator, next generator value
  taps_t             taps_r[2], taps_nxt[2];
  logic [BYTE_W-1:0] rnd_lo_r[2], rnd_lo_nxt[2];
  logic [SEED_W-1:0] rnd_ahead_r[2], rnd_ahead_nxt[2];

  logic              adv, in_acc, cfg_wr, seed_wr, dith_fire, ch;
  taps_t             cur_taps, new_taps;
  logic [BYTE_W-1:0] cur_lo;
  logic [SEED_W-1:0] cur_ahead, pm_in, pm_out;
  logic [HALF_W-1:0] word16;

  // Handshake
  always_comb begin
    adv       = s1_v_r && (!out_v_r || !out_stall);
    in_stall  = s1_v_r && !adv;
    in_acc    = in_valid && !in_stall;
    cfg_ready = 1'b1;
    cfg_wr    = cfg_valid && cfg_ready;
    seed_wr   = cfg_wr && (cfg_index == CFG_SEED);
    out_valid = out_v_r;
    out_item  = out_item_r;
  end

  // Channel state select
  always_comb begin
    ch        = stereo_r & s1_item_r.channel;
    cur_taps  = taps_r[ch];
    cur_lo    = rnd_lo_r[ch];
    cur_ahead = rnd_ahead_r[ch];
    dith_fire = adv && (bps_r == BPS_24);
    // one generator step, shared by seed load and dither
    pm_in     = seed_wr ? cfg_data : cur_ahead;
  end

  pcmfd_lcg u_lcg (
    .state_in  (pm_in),
    .state_out (pm_out)
  );

  pcmfd_dither u_dither (
    .sample     (s1_item_r.sample),
    .taps       (cur_taps),
    .rnd_old_lo (cur_lo),
    .rnd_new_lo (cur_ahead[BYTE_W-1:0]),
    .taps_nxt   (new_taps),
    .word16     (word16)
  );

  // Output formatting by sample size
  always_comb begin
    out_item_nxt = out_item_r;
    if (adv) begin
      case (bps_r)
        BPS_8: begin
          out_item_nxt.out_word  = {24'b0, s1_item_r.sample[BYTE_W-1:0] + BYTE_W'(BYTE_BIAS)};
          out_item_nxt.out_bytes = BPS_8;
        end
        BPS_16: begin
          out_item_nxt.out_word  = {16'b0, s1_item_r.sample[HALF_W-1:0]};
          out_item_nxt.out_bytes = BPS_16;
        end
        BPS_24: begin
          out_item_nxt.out_word  = {16'b0, word16};
          out_item_nxt.out_bytes = BPS_16;
        end
        BPS_32: begin
          out_item_nxt.out_word  = s1_item_r.sample;
          out_item_nxt.out_bytes = BPS_32;
        end
        default: begin
          out_item_nxt.out_word  = '0;
          out_item_nxt.out_bytes = '0;
        end
      endcase
    end
  end

  // Pipeline valid bits
  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    out_v_nxt = adv ? 1'b1 : (out_stall ? out_v_r : 1'b0);
  end

  // Config register writes
  always_comb begin
    bps_nxt    = bps_r;
    stereo_nxt = stereo_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_BPS:    bps_nxt    = cfg_data[BPS_W-1:0];
        CFG_STEREO: stereo_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Channel state update
  always_comb begin
    taps_nxt      = taps_r;
    rnd_lo_nxt    = rnd_lo_r;
    rnd_ahead_nxt = rnd_ahead_r;
    if (seed_wr) begin
      for (int i = 0; i < 2; i++) begin
        rnd_lo_nxt[i]    = cfg_data[BYTE_W-1:0];
        rnd_ahead_nxt[i] = pm_out;
      end
    end else if (dith_fire) begin
      taps_nxt[ch]      = new_taps;
      rnd_lo_nxt[ch]    = cur_ahead[BYTE_W-1:0];
      rnd_ahead_nxt[ch] = pm_out;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r    <= BPS_RESET;
      stereo_r <= 1'b1;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        taps_r[i]      <= '0;
        rnd_lo_r[i]    <= SEED_RESET[BYTE_W-1:0];
        rnd_ahead_r[i] <= RND_AHEAD_RESET;
      end
    end else begin
      bps_r       <= bps_nxt;
      stereo_r    <= stereo_nxt;
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
      taps_r      <= taps_nxt;
      rnd_lo_r    <= rnd_lo_nxt;
      rnd_ahead_r <= rnd_ahead_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_item;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== sv/pcmfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmfd_checker
// Port-level checks on the PCM formatter, bound to the top level.
// ----------------------------------------------------------------------------
module pcmfd_checker
  import pcmfd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // Byte count is a legal size
  a_bytes_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.out_bytes == 3'd0 || out_item.out_bytes == 3'd1 ||
                   out_item.out_bytes == 3'd2 || out_item.out_bytes == 3'd4))
    else $error("illegal byte count");

  // The upper two bytes of a one- or two-byte word are zero
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.out_bytes == 3'd1 || out_item.out_bytes == 3'd2) |->
      out_item.out_word[31:16] == 16'h0)
    else $error("unused output bytes not zero");

endmodule

bind pcm_format_with_noise_shaped_dither pcmfd_checker u_pcmfd_checker (.*);

// ===== tb/pcm_format_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_format_checker
// Watches the item, result and register channels of the PCM formatter. It
// keeps its own copy of the registers, feedback taps and generators, works
// out the formatted word for every accepted item and compares each accepted
// result with the oldest one waiting.
// ----------------------------------------------------------------------------
module pcm_format_checker
  import pcmfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data,
  output int                   words_pending,
  output int                   words_checked,
  output int                   mismatches
);

  localparam longint CLIP_HI = 8388607;
  localparam longint CLIP_LO = -8388608;

  // Register copies
  logic [BPS_W-1:0]  cur_bps;
  logic              cur_stereo;

  // Per-channel feedback taps and generator state
  int                recent_err [2];
  int                halved_err [2];
  int                oldest_err [2];
  logic [SEED_W-1:0] gen_state  [2];

  out_item_t         expected_words [$];

  initial begin
    words_pending = 0;
    words_checked = 0;
    mismatches    = 0;
  end

  // Park-Miller step over the full product
  function automatic logic [SEED_W-1:0] park_miller(logic [SEED_W-1:0] a);
    longint unsigned p;
    p = a;
    p = (p * LCG_MULT) % LCG_MOD;
    return p[SEED_W-1:0];
  endfunction

  // 24-bit sample to 16 bits: noise shaping, dither, clip, drop low byte
  function automatic logic [15:0] dither_to_16(logic signed [31:0] smp, logic ch);
    longint            acc;
    longint            outv;
    longint            rnd_lo;
    longint            old_lo;
    logic [SEED_W-1:0] rnd;
    logic [63:0]       bits;
    acc = smp;
    acc = acc + recent_err[ch] - halved_err[ch] + oldest_err[ch];
    oldest_err[ch] = halved_err[ch];
    halved_err[ch] = recent_err[ch] / 2;  // truncates toward zero

    rnd    = park_miller(gen_state[ch]);
    rnd_lo = rnd[7:0];
    old_lo = gen_state[ch][7:0];
    outv   = acc + BYTE_BIAS + rnd_lo - old_lo;
    gen_state[ch] = rnd;

    if (outv > CLIP_HI) begin
      outv = CLIP_HI;
      if (acc > CLIP_HI) acc = CLIP_HI;
    end else if (outv < CLIP_LO) begin
      outv = CLIP_LO;
      if (acc < CLIP_LO) acc = CLIP_LO;
    end

    outv = outv - (outv & 64'hff);
    recent_err[ch] = int'(acc - outv);
    bits = outv;
    return bits[23:8];
  endfunction

  // Expected result of one item under the current registers
  function automatic out_item_t format_item(in_item_t it);
    out_item_t r;
    logic      ch;
    r  = '0;
    ch = cur_stereo ? it.channel : 1'b0;
    case (cur_bps)
      BPS_8: begin
        r.out_word  = {24'b0, it.sample[7:0] + 8'(BYTE_BIAS)};
        r.out_bytes = 3'd1;
      end
      BPS_16: begin
        r.out_word  = {16'b0, it.sample[15:0]};
        r.out_bytes = 3'd2;
      end
      BPS_24: begin
        r.out_word  = {16'b0, dither_to_16(it.sample, ch)};
        r.out_bytes = 3'd2;
      end
      BPS_32: begin
        r.out_word  = it.sample;
        r.out_bytes = 3'd4;
      end
      default: ;  // unsupported size: zero word, no bytes, state kept
    endcase
    return r;
  endfunction

  // Register writes, then accepted items, then accepted results
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cur_bps    = BPS_RESET;
      cur_stereo = 1'b1;
      recent_err = '{0, 0};
      halved_err = '{0, 0};
      oldest_err = '{0, 0};
      gen_state  = '{SEED_RESET, SEED_RESET};
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_BPS:    cur_bps    = cfg_data[BPS_W-1:0];
          CFG_STEREO: cur_stereo = cfg_data[0];
          CFG_SEED:   gen_state  = '{cfg_data, cfg_data};
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        expected_words.push_back(format_item(in_item));

      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word=%h bytes=%0d", $time,
                   out_item.out_word, out_item.out_bytes);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (want.out_word !== out_item.out_word) begin
            mismatches++;
            $display("%0t: out_word expected %h actual %h", $time,
                     want.out_word, out_item.out_word);
          end
          if (want.out_bytes !== out_item.out_bytes) begin
            mismatches++;
            $display("%0t: out_bytes expected %0d actual %0d", $time,
                     want.out_bytes, out_item.out_bytes);
          end
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== tb/pcm_format_with_noise_shaped_dither_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_format_with_noise_shaped_dither_tb
// Drives samples and register writes into the PCM formatter. A directed
// pass hits the sample extremes, every size code, mono operation and the
// degenerate seeds; random blocks then run long dithered streams with
// changing sizes, channel modes and seeds under varying sender and receiver
// idling, including a long receiver hold-off. Checking is in the checker.
// ----------------------------------------------------------------------------
module pcm_format_with_noise_shaped_dither_tb;
  import pcmfd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_GAP    = 6;
  localparam int BLOCK_ITEMS  = 72;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEED_W-1:0]    cfg_data  = '0;

  int words_pending;
  int words_checked;
  int mismatches;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   cycle_count  = 0;
  int   items_sent   = 0;
  int   reg_writes   = 0;

  pcm_format_with_noise_shaped_dither dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcm_format_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Offer one item, with a random gap first; valid stays high afterwards
  task automatic send(logic [31:0] smp, logic ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{sample: smp, channel: ch};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SEED_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Sample shaped for the size in use: mostly in range, some near the
  // clip points, some raw 32-bit noise
  function automatic logic [31:0] pick_sample(logic [BPS_W-1:0] bps);
    int          r;
    int          d;
    logic [31:0] v;
    r = $urandom_range(99);
    d = $urandom_range(300);
    v = $urandom;
    if (r < 20) return v;
    case (bps)
      BPS_8:  return {{24{v[7]}}, v[7:0]};
      BPS_16: return {{16{v[15]}}, v[15:0]};
      BPS_24: begin
        if (r < 32) return v[0] ? 32'(CLIP_MAX) - d : 32'(CLIP_MIN) + d;
        return {{8{v[23]}}, v[23:0]};
      end
      default: return v;
    endcase
  endfunction

  function automatic logic [SEED_W-1:0] pick_seed();
    case ($urandom_range(9))
      0:       return SEED_RESET;
      1:       return LCG_MOD - 1'b1;
      2:       return '0;        // generator sticks at zero
      3:       return LCG_MOD;   // same
      default: return SEED_W'($urandom_range(32'h7fff_fffe, 1));
    endcase
  endfunction

  initial begin
    logic [BPS_W-1:0] bps_pick;
    logic             stereo_pick;
    logic             ch;
    int               r;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Dither path at reset settings: range ends and clipping on both channels
    send(32'd0, 1'b0);
    send(32'(CLIP_MAX), 1'b0);
    send(32'(CLIP_MIN), 1'b1);
    send(32'h7fff_ffff, 1'b1);
    send(32'h8000_0000, 1'b0);
    send(32'hffff_ffff, 1'b1);

    // Mono: channel field ignored
    drain();
    write_reg(CFG_STEREO, '0);
    send(32'd100, 1'b1);
    send(-32'sd100, 1'b0);

    // Degenerate seeds, then the largest usable one
    drain();
    write_reg(CFG_STEREO, SEED_W'(1));
    write_reg(CFG_SEED, '0);
    send(32'd1000, 1'b0);
    send(32'd1000, 1'b1);
    drain();
    write_reg(CFG_SEED, LCG_MOD);
    send(32'd5, 1'b0);
    drain();
    write_reg(CFG_SEED, LCG_MOD - 1'b1);
    send(-32'sd5, 1'b1);

    // Pass-through sizes
    drain();
    write_reg(CFG_BPS, SEED_W'(BPS_8));
    send(32'd127, 1'b0);
    send(-32'sd128, 1'b1);
    send(32'hffff_ff7f, 1'b0);
    send(32'd255, 1'b1);
    drain();
    write_reg(CFG_BPS, SEED_W'(BPS_16));
    send(32'h1234_8000, 1'b0);
    send(32'hffff_ffff, 1'b1);
    drain();
    write_reg(CFG_BPS, SEED_W'(BPS_32));
    send(32'h8000_0000, 1'b0);
    send(32'h7fff_ffff, 1'b1);

    // Every unsupported size code
    for (int b = 0; b < 8; b++) begin
      if (BPS_W'(b) < BPS_8 || BPS_W'(b) > BPS_32) begin
        drain();
        write_reg(CFG_BPS, SEED_W'(b));
        send($urandom, 1'($urandom));
      end
    end

    // Random blocks in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 19; rx_stall_pct <= 45; end
        1: begin tx_idle_pct = 45; rx_stall_pct <= 19; end
        default: begin tx_idle_pct = 0; rx_stall_pct <= 0; end
      endcase
      for (int blk = 0; blk < 6; blk++) begin
        r = $urandom_range(99);
        if (r < 50)      bps_pick = BPS_24;
        else if (r < 62) bps_pick = BPS_8;
        else if (r < 74) bps_pick = BPS_16;
        else if (r < 88) bps_pick = BPS_32;
        else begin
          bps_pick = BPS_W'($urandom);
          while (bps_pick >= BPS_8 && bps_pick <= BPS_32) bps_pick = BPS_W'($urandom);
        end
        stereo_pick = 1'($urandom);

        drain();
        write_reg(CFG_BPS, SEED_W'(bps_pick));
        write_reg(CFG_STEREO, SEED_W'(stereo_pick));
        if ($urandom_range(99) < 40) write_reg(CFG_SEED, pick_seed());

        // Long receiver hold-off while items keep coming
        if (ph == 2 && (blk == 0 || blk == 3)) hold_req <= ~hold_req;

        ch = 1'($urandom);
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          // stereo streams mostly alternate channels
          ch = ($urandom_range(99) < 80) ? ~ch : 1'($urandom);
          send(pick_sample(bps_pick), ch);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("sent %0d items, checked %0d results, %0d register writes", items_sent,
             words_checked, reg_writes);
    $display("modes: 8/16/24/32-bit and unsupported sizes, mono and stereo, edge seeds");
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
